// File: rtl/core/presence_dwell_and_swipe_detector_macros.svh
// Assertion macros for the presence dwell and swipe detector.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef PRESENCE_DWELL_AND_SWIPE_DETECTOR_MACROS_SVH
`define PRESENCE_DWELL_AND_SWIPE_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define PSD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define PSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSD_ASSERT_SAME(lbl, ante, cons)
`define PSD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/psd_pkg.sv
// Shared constants and types of the presence dwell and swipe detector.
// No dependencies; used by every module of the block.
package psd_pkg;

  localparam int DEF_SAMPLE_BITS = 10;
  localparam int DEF_TIME_BITS   = 32;
  localparam int DEF_COUNT_BITS  = 16;

  localparam int NOW_W      = 32;
  localparam int COUNT_W    = 16;
  localparam int DWELL_W    = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam int RST_PRES_THR  = 15;
  localparam int RST_SWIPE_THR = 15;
  localparam int RST_HYST      = 2;
  localparam int RST_DWELL     = 2000;

  typedef enum logic [1:0] {
    REG_PRES_THR  = 2'd0,
    REG_SWIPE_THR = 2'd1,
    REG_HYST      = 2'd2,
    REG_DWELL     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic active;
    logic timing;
    logic armed;
  } flags_t;

  typedef struct packed {
    logic entered;
    logic exited;
    logic swiped;
  } events_t;

endpackage

// File: rtl/core/psd_cfg.sv
// Configuration register file with an APB-style write and read port.
// Depends on psd_pkg for register indexes and reset values.
module psd_cfg #(
  parameter int SAMPLE_BITS = psd_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [psd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [psd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output logic [SAMPLE_BITS-1:0]        pres_thr,
  output logic [SAMPLE_BITS-1:0]        swipe_thr,
  output logic [SAMPLE_BITS-1:0]        hyst,
  output logic [psd_pkg::DWELL_W-1:0]   dwell
);
  import psd_pkg::*;

  logic [SAMPLE_BITS-1:0] pres_thr_r, pres_thr_nxt;
  logic [SAMPLE_BITS-1:0] swipe_thr_r, swipe_thr_nxt;
  logic [SAMPLE_BITS-1:0] hyst_r, hyst_nxt;
  logic [DWELL_W-1:0]     dwell_r, dwell_nxt;
  logic                   wr_en;
  reg_idx_t               idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_comb begin
    pres_thr_nxt  = pres_thr_r;
    swipe_thr_nxt = swipe_thr_r;
    hyst_nxt      = hyst_r;
    dwell_nxt     = dwell_r;
    if (wr_en) begin
      unique case (idx)
        REG_PRES_THR:  pres_thr_nxt  = pwdata[SAMPLE_BITS-1:0];
        REG_SWIPE_THR: swipe_thr_nxt = pwdata[SAMPLE_BITS-1:0];
        REG_HYST:      hyst_nxt      = pwdata[SAMPLE_BITS-1:0];
        REG_DWELL:     dwell_nxt     = pwdata[DWELL_W-1:0];
        default:       dwell_nxt     = dwell_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PRES_THR:  prdata = CFG_DATA_W'(pres_thr_r);
      REG_SWIPE_THR: prdata = CFG_DATA_W'(swipe_thr_r);
      REG_HYST:      prdata = CFG_DATA_W'(hyst_r);
      REG_DWELL:     prdata = CFG_DATA_W'(dwell_r);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_thr_r  <= SAMPLE_BITS'(RST_PRES_THR);
      swipe_thr_r <= SAMPLE_BITS'(RST_SWIPE_THR);
      hyst_r      <= SAMPLE_BITS'(RST_HYST);
      dwell_r     <= DWELL_W'(RST_DWELL);
    end else begin
      pres_thr_r  <= pres_thr_nxt;
      swipe_thr_r <= swipe_thr_nxt;
      hyst_r      <= hyst_nxt;
      dwell_r     <= dwell_nxt;
    end
  end

  assign pres_thr  = pres_thr_r;
  assign swipe_thr = swipe_thr_r;
  assign hyst      = hyst_r;
  assign dwell     = dwell_r;

endmodule

// File: rtl/core/psd_step.sv
// Next-state logic for one sample: entry and exit dwell timing and swipe counting.
// Depends on psd_pkg for the flag and event structs.
module psd_step #(
  parameter int SAMPLE_BITS = psd_pkg::DEF_SAMPLE_BITS,
  parameter int TIME_BITS   = psd_pkg::DEF_TIME_BITS,
  parameter int COUNT_BITS  = psd_pkg::DEF_COUNT_BITS
) (
  input  psd_pkg::flags_t             flags,
  input  logic [TIME_BITS-1:0]        start,
  input  logic [COUNT_BITS-1:0]       total,
  input  logic [SAMPLE_BITS-1:0]      pres,
  input  logic [SAMPLE_BITS-1:0]      swp,
  input  logic [TIME_BITS-1:0]        now,
  input  logic [SAMPLE_BITS-1:0]      pres_thr,
  input  logic [SAMPLE_BITS-1:0]      swipe_thr,
  input  logic [SAMPLE_BITS-1:0]      hyst,
  input  logic [psd_pkg::DWELL_W-1:0] dwell,
  output psd_pkg::flags_t             flags_nxt,
  output logic [TIME_BITS-1:0]        start_nxt,
  output logic [COUNT_BITS-1:0]       total_nxt,
  output psd_pkg::events_t            ev
);
  import psd_pkg::*;

  logic [TIME_BITS-1:0] elapsed;
  logic                 done;
  logic                 pres_high;
  logic                 pres_low;
  logic                 swp_high;
  logic                 swp_low;
  flags_t               f;

  // Elapsed time wraps with the timestamp.
  assign elapsed = now - start;
  assign done    = elapsed >= TIME_BITS'(dwell);

  // "Below threshold minus hysteresis" is evaluated as sample + hysteresis < threshold
  // with one extra bit, which matches the signed comparison.
  assign pres_high = pres > pres_thr;
  assign pres_low  = ({1'b0, pres} + {1'b0, hyst}) < {1'b0, pres_thr};
  assign swp_high  = swp > swipe_thr;
  assign swp_low   = ({1'b0, swp} + {1'b0, hyst}) < {1'b0, swipe_thr};

  always_comb begin
    f         = flags;
    start_nxt = start;
    total_nxt = total;
    ev        = '0;

    if (pres_high && !flags.active) begin
      if (!flags.timing) begin
        f.timing  = 1'b1;
        start_nxt = now;
      end else if (done) begin
        f.active   = 1'b1;
        f.timing   = 1'b0;
        total_nxt  = '0;
        ev.entered = 1'b1;
      end
    end

    // High and low presence exclude each other, so the original flags apply here.
    if (pres_low) begin
      if (flags.active) begin
        if (!flags.timing) begin
          f.timing  = 1'b1;
          start_nxt = now;
        end else if (done) begin
          f.active  = 1'b0;
          ev.exited = 1'b1;
        end
      end else if (flags.timing && done) begin
        f.timing = 1'b0;
      end
    end

    if (f.active) begin
      if (!f.armed && swp_high) begin
        f.armed = 1'b1;
      end
      if (f.armed && swp_low) begin
        f.armed   = 1'b0;
        ev.swiped = 1'b1;
        if (total_nxt != {COUNT_BITS{1'b1}}) begin
          total_nxt = total_nxt + COUNT_BITS'(1);
        end
      end
    end

    flags_nxt = f;
  end

endmodule

// File: rtl/core/presence_dwell_and_swipe_detector.sv
// Presence dwell and swipe detector, top level.
// Uses psd_pkg, psd_cfg, psd_step and the assertion macro header.
//
// Usage: each input item carries a presence sample, a swipe sample and a
// millisecond timestamp. An item is accepted at a rising edge where in_valid
// is high and in_stall is low. Every accepted item produces exactly one
// result item on the out_ channel, taken when out_valid is high and
// out_stall is low.
// The input item is first captured in an input register. Once the output
// register is free or being drained, the dwell timing, hysteresis compares
// and swipe counting settle in one pass of logic, the detector state is
// updated and the result is loaded into the output register, which raises
// out_valid. One item is taken every cycle when the receiver keeps up.
// When the receiver stalls, the result holds in the output register and the
// next item waits in the input register; in_stall rises only when both are
// occupied and the receiver is stalling, so throughput recovers as soon as
// the stall is released.
// Synchronous reset clears the detector state (inactive, not timing, not
// armed, zero swipes), empties both registers and restores the
// configuration registers to their defaults. Configuration must be written over the
// APB-style port only while no item is in flight; the block does not enforce this.
`include "presence_dwell_and_swipe_detector_macros.svh"

module presence_dwell_and_swipe_detector #(
  parameter int SAMPLE_BITS = psd_pkg::DEF_SAMPLE_BITS,
  parameter int TIME_BITS   = psd_pkg::DEF_TIME_BITS,
  parameter int COUNT_BITS  = psd_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [psd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [psd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [psd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [SAMPLE_BITS-1:0]         in_presence_sample,
  input  logic [SAMPLE_BITS-1:0]         in_swipe_sample,
  input  logic [psd_pkg::NOW_W-1:0]      in_now_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_is_active,
  output logic                           out_is_timing,
  output logic                           out_swipe_armed,
  output logic [psd_pkg::COUNT_W-1:0]    out_swipe_count,
  output logic                           out_entered,
  output logic                           out_exited,
  output logic                           out_swiped
);
  import psd_pkg::*;

  // Configuration registers.
  logic [SAMPLE_BITS-1:0] pres_thr;
  logic [SAMPLE_BITS-1:0] swipe_thr;
  logic [SAMPLE_BITS-1:0] hyst;
  logic [DWELL_W-1:0]     dwell;

  psd_cfg #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .pres_thr (pres_thr),
    .swipe_thr(swipe_thr),
    .hyst     (hyst),
    .dwell    (dwell)
  );

  // Input register. The timestamp is reduced to the timer width on capture.
  logic                   in_valid_r;
  logic [SAMPLE_BITS-1:0] pres_r;
  logic [SAMPLE_BITS-1:0] swp_r;
  logic [TIME_BITS-1:0]   now_r;
  logic                   in_load;
  logic                   adv;

  // The held item moves on whenever the output register is free or being drained.
  assign adv      = in_valid_r && (!out_valid || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_load) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      pres_r <= in_presence_sample;
      swp_r  <= in_swipe_sample;
      now_r  <= TIME_BITS'(in_now_ms);
    end
  end

  // Detector state, updated once per item as it moves to the output register.
  flags_t                flags_r, flags_nxt;
  logic [TIME_BITS-1:0]  start_r, start_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  events_t               ev;

  psd_step #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .flags    (flags_r),
    .start    (start_r),
    .total    (total_r),
    .pres     (pres_r),
    .swp      (swp_r),
    .now      (now_r),
    .pres_thr (pres_thr),
    .swipe_thr(swipe_thr),
    .hyst     (hyst),
    .dwell    (dwell),
    .flags_nxt(flags_nxt),
    .start_nxt(start_nxt),
    .total_nxt(total_nxt),
    .ev       (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      start_r <= '0;
      total_r <= '0;
    end else if (adv) begin
      flags_r <= flags_nxt;
      start_r <= start_nxt;
      total_r <= total_nxt;
    end
  end

  // Output register. Its valid stays up until the receiver takes the item.
  logic               out_valid_r;
  flags_t             out_flags_r;
  events_t            out_ev_r;
  logic [COUNT_W-1:0] out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_flags_r <= flags_nxt;
      out_ev_r    <= ev;
      out_count_r <= COUNT_W'(total_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_active   = out_flags_r.active;
  assign out_is_timing   = out_flags_r.timing;
  assign out_swipe_armed = out_flags_r.armed;
  assign out_swipe_count = out_count_r;
  assign out_entered     = out_ev_r.entered;
  assign out_exited      = out_ev_r.exited;
  assign out_swiped      = out_ev_r.swiped;

  // The active flag changes exactly when the item just loaded reports an entry or exit.
  `PSD_ASSERT_NEXT(a_active_change_has_event, adv,
    (flags_r.active != $past(flags_r.active)) == (out_ev_r.entered || out_ev_r.exited))
  // A swipe is only counted while the block is active.
  `PSD_ASSERT_SAME(a_swipe_only_active, out_valid_r && out_swiped, out_is_active)
  // Entry clears the count, so at most this item's own swipe is counted.
  `PSD_ASSERT_SAME(a_entry_clears_count, out_valid_r && out_entered,
    out_swipe_count == COUNT_W'(out_swiped))

endmodule

// File: dv/tb_presence_dwell_and_swipe_detector.sv
// Self-checking testbench for the presence dwell and swipe detector.
// Needs psd_pkg and the detector RTL; drives the sample stream and the APB-style
// configuration port, predicts every result and checks it.
module tb_presence_dwell_and_swipe_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import psd_pkg::*;

  localparam int SW = DEF_SAMPLE_BITS;
  localparam logic [SW-1:0] LEVEL_MAX = '1;
  // Cycles the receiver holds off in the back-pressure phase.
  localparam int HOLD_OFF_CYCLES = 60;
  // Swipes in the back-to-back swipe burst.
  localparam int SWIPE_BURST = 12;
  // Depth of the pending-item queue that feeds the driver.
  localparam int FEED_DEPTH = 4;

  // One input item and one result item, at the block's widths.
  typedef struct packed {
    logic [SW-1:0]    presence;
    logic [SW-1:0]    swipe;
    logic [NOW_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic               active;
    logic               timing;
    logic               armed;
    logic [COUNT_W-1:0] count;
    logic               entered;
    logic               exited;
    logic               swiped;
  } outcome_t;

  // Where a generated reading falls relative to a threshold and its hysteresis band.
  typedef enum {LVL_LOW, LVL_MID, LVL_HIGH} level_t;

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  in_valid           = 1'b0;
  logic                  in_stall;
  logic [SW-1:0]         in_presence_sample = '0;
  logic [SW-1:0]         in_swipe_sample    = '0;
  logic [NOW_W-1:0]      in_now_ms          = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_is_active;
  logic                  out_is_timing;
  logic                  out_swipe_armed;
  logic [COUNT_W-1:0]    out_swipe_count;
  logic                  out_entered;
  logic                  out_exited;
  logic                  out_swiped;

  presence_dwell_and_swipe_detector i_dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers, at their reset values.
  logic [SW-1:0]      thr_presence = SW'(RST_PRES_THR);
  logic [SW-1:0]      thr_swipe    = SW'(RST_SWIPE_THR);
  logic [SW-1:0]      hyst_margin  = SW'(RST_HYST);
  logic [DWELL_W-1:0] dwell_limit  = DWELL_W'(RST_DWELL);

  // Predicted detector state, all clear after reset.
  logic               st_active   = 1'b0;
  logic               st_timing   = 1'b0;
  logic [NOW_W-1:0]   dwell_start = '0;
  logic               st_armed    = 1'b0;
  logic [COUNT_W-1:0] swipe_total = '0;

  sample_t  samples_to_send[$];
  outcome_t outcomes_due[$];
  sample_t  current_item;

  // Timestamp the stimulus generator has reached.
  logic [NOW_W-1:0] clock_ms = '0;

  int items_queued   = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int mismatch_count = 0;
  int entry_total    = 0;
  int exit_total     = 0;
  int swipe_events   = 0;

  // Handshake pacing, set per phase by the stimulus process.
  logic sender_idles   = 1'b1;
  logic receiver_idles = 1'b1;
  logic hold_request   = 1'b0;
  logic hold_started   = 1'b0;
  int   send_gap       = 0;
  int   stall_left     = 0;
  int   hold_left      = 0;

  // A reading is low when it lies below threshold minus hysteresis, compared
  // signed, so a negative bound can never be met.
  function automatic logic under_band(logic [SW-1:0] level, logic [SW-1:0] thr);
    return int'(level) < int'(thr) - int'(hyst_margin);
  endfunction

  // Elapsed time wraps modulo 2^32, just like the free-running timestamp.
  function automatic logic dwell_met(logic [NOW_W-1:0] now);
    logic [NOW_W-1:0] elapsed;
    elapsed = now - dwell_start;
    return elapsed >= NOW_W'(dwell_limit);
  endfunction

  // Applies one sample to the predicted state and returns the result it must
  // produce. The order matters: entry check, then low presence, then swipes
  // with the already updated active flag.
  function automatic outcome_t advance_detector(sample_t s);
    outcome_t r;
    r = '0;
    if (s.presence > thr_presence && !st_active) begin
      if (!st_timing) begin
        st_timing   = 1'b1;
        dwell_start = s.now_ms;
      end else if (dwell_met(s.now_ms)) begin
        st_active   = 1'b1;
        st_timing   = 1'b0;
        swipe_total = '0;
        r.entered   = 1'b1;
      end
    end
    if (under_band(s.presence, thr_presence)) begin
      if (st_active) begin
        // High samples never cancel the exit timing, and exit leaves the
        // timing flag and start time as they are.
        if (!st_timing) begin
          st_timing   = 1'b1;
          dwell_start = s.now_ms;
        end else if (dwell_met(s.now_ms)) begin
          st_active = 1'b0;
          r.exited  = 1'b1;
        end
      end else if (st_timing && dwell_met(s.now_ms)) begin
        st_timing = 1'b0;
      end
    end
    if (st_active) begin
      if (!st_armed && s.swipe > thr_swipe) st_armed = 1'b1;
      if (st_armed && under_band(s.swipe, thr_swipe)) begin
        st_armed = 1'b0;
        if (swipe_total != '1) swipe_total = swipe_total + 1'b1;
        r.swiped = 1'b1;
      end
    end
    r.active = st_active;
    r.timing = st_timing;
    r.armed  = st_armed;
    r.count  = swipe_total;
    return r;
  endfunction

  // Driver: records each accepted item with its prediction, then offers the
  // next pending item unless an idle burst is running.
  always @(posedge clk) begin : sample_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        outcomes_due.insert(outcomes_due.size(), advance_detector(current_item));
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (samples_to_send.size() != 0) begin
          current_item = samples_to_send.pop_front();
          in_valid           <= 1'b1;
          in_presence_sample <= current_item.presence;
          in_swipe_sample    <= current_item.swipe;
          in_now_ms          <= current_item.now_ms;
          if (sender_idles && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string field, logic [COUNT_W-1:0] want,
                             logic [COUNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: checks each accepted result against the oldest prediction and
  // paces out_stall with random bursts and the one long hold-off.
  always @(posedge clk) begin : result_monitor
    outcome_t due;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (outcomes_due.size() == 0) begin
          $display("%0t ns: result item with no prediction outstanding", $time);
          mismatch_count++;
        end else begin
          due = outcomes_due.pop_front();
          check_field("is_active", COUNT_W'(due.active), COUNT_W'(out_is_active));
          check_field("is_timing", COUNT_W'(due.timing), COUNT_W'(out_is_timing));
          check_field("swipe_armed", COUNT_W'(due.armed), COUNT_W'(out_swipe_armed));
          check_field("swipe_count", due.count, out_swipe_count);
          check_field("entered", COUNT_W'(due.entered), COUNT_W'(out_entered));
          check_field("exited", COUNT_W'(due.exited), COUNT_W'(out_exited));
          check_field("swiped", COUNT_W'(due.swiped), COUNT_W'(out_swiped));
          entry_total  += int'(due.entered);
          exit_total   += int'(due.exited);
          swipe_events += int'(due.swiped);
        end
      end
      if (hold_request && !hold_started) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_started = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (receiver_idles && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_access(logic write, reg_idx_t idx, logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Writes a register with junk above its width, which the block must drop,
  // updates the shadow copy and reads the register back.
  task automatic program_reg(reg_idx_t idx, int unsigned value);
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_DATA_W-1:0] kept;
    logic [CFG_DATA_W-1:0] readback;
    int                    width;
    width = (idx == REG_DWELL) ? DWELL_W : SW;
    junk  = CFG_DATA_W'($urandom()) << width;
    kept  = CFG_DATA_W'(value) & ((CFG_DATA_W'(1) << width) - 1);
    apb_access(1'b1, idx, CFG_DATA_W'(value) | junk, readback);
    case (idx)
      REG_PRES_THR:  thr_presence = SW'(kept);
      REG_SWIPE_THR: thr_swipe    = SW'(kept);
      REG_HYST:      hyst_margin  = SW'(kept);
      default:       dwell_limit  = DWELL_W'(kept);
    endcase
    apb_access(1'b0, idx, '0, readback);
    if (readback !== kept) begin
      $display("%0t ns: register %s reads back wrong, expected %0d, actual %0d",
               $time, idx.name(), kept, readback);
      mismatch_count++;
    end
  endtask

  // Waits until no item is queued, offered or awaiting its result.
  task automatic wait_idle();
    do @(negedge clk);
    while (samples_to_send.size() != 0 || in_valid || outcomes_due.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic apply_setting(int unsigned pres_thr, int unsigned swipe_thr,
                               int unsigned hyst, int unsigned dwell);
    wait_idle();
    program_reg(REG_PRES_THR, pres_thr);
    program_reg(REG_SWIPE_THR, swipe_thr);
    program_reg(REG_HYST, hyst);
    program_reg(REG_DWELL, dwell);
  endtask

  // Queues one item; blocks while the feed queue is full.
  task automatic offer(logic [SW-1:0] pres, logic [SW-1:0] swp, logic [NOW_W-1:0] now);
    sample_t s;
    s.presence = pres;
    s.swipe    = swp;
    s.now_ms   = now;
    while (samples_to_send.size() >= FEED_DEPTH) @(negedge clk);
    samples_to_send.insert(samples_to_send.size(), s);
    items_queued++;
  endtask

  function automatic logic [NOW_W-1:0] tick(int unsigned step);
    clock_ms = clock_ms + NOW_W'(step);
    return clock_ms;
  endfunction

  // Draws a reading in the requested band under the current setting, hitting
  // the band edges now and then. Where a band is empty the nearest value is used.
  function automatic logic [SW-1:0] pick_level(level_t kind, logic [SW-1:0] thr);
    int   floor_lvl;
    int   lo;
    logic edge_pick;
    floor_lvl = int'(thr) - int'(hyst_margin);
    lo        = (floor_lvl < 0) ? 0 : floor_lvl;
    edge_pick = ($urandom_range(0, 3) == 0);
    case (kind)
      LVL_HIGH: begin
        if (thr == LEVEL_MAX) return LEVEL_MAX;
        if (edge_pick) return thr + 1'b1;
        return SW'($urandom_range(int'(LEVEL_MAX), int'(thr) + 1));
      end
      LVL_LOW: begin
        if (floor_lvl <= 0) return '0;
        if (edge_pick) return SW'(floor_lvl - 1);
        return SW'($urandom_range(floor_lvl - 1, 0));
      end
      default: begin
        if (edge_pick) return ($urandom_range(0, 1) == 0) ? thr : SW'(lo);
        return SW'($urandom_range(int'(thr), lo));
      end
    endcase
  endfunction

  function automatic logic [SW-1:0] any_swipe();
    return pick_level(level_t'($urandom_range(0, 2)), thr_swipe);
  endfunction

  // One visit: a low stretch that clears earlier state, a dwell-long rise,
  // a stay with swipes, and a low stretch long enough to leave.
  task automatic run_episode();
    int unsigned stride;
    level_t      kind;
    stride = int'(dwell_limit) / 3 + 1;
    repeat ($urandom_range(1, 3))
      offer(pick_level(LVL_LOW, thr_presence), any_swipe(),
            tick(int'(dwell_limit) + $urandom_range(0, 3)));
    offer(pick_level(LVL_HIGH, thr_presence), any_swipe(), tick($urandom_range(1, stride)));
    if (dwell_limit != 0 && $urandom_range(0, 1) == 0) begin
      // One millisecond short of the dwell, then exactly on it.
      offer(pick_level(LVL_HIGH, thr_presence), any_swipe(), tick(int'(dwell_limit) - 1));
      offer(pick_level(LVL_HIGH, thr_presence), any_swipe(), tick(1));
    end else begin
      repeat (4) begin
        kind = ($urandom_range(0, 4) == 0) ? LVL_MID : LVL_HIGH;
        offer(pick_level(kind, thr_presence), any_swipe(), tick(stride));
      end
    end
    repeat ($urandom_range(2, 8)) begin
      kind = ($urandom_range(0, 9) == 0) ? LVL_LOW :
             ($urandom_range(0, 1) == 0) ? LVL_MID : LVL_HIGH;
      offer(pick_level(kind, thr_presence), pick_level(LVL_HIGH, thr_swipe),
            tick($urandom_range(0, stride)));
      if ($urandom_range(0, 2) == 0)
        offer(pick_level(LVL_MID, thr_presence), pick_level(LVL_MID, thr_swipe),
              tick($urandom_range(0, stride)));
      offer(pick_level(LVL_HIGH, thr_presence), pick_level(LVL_LOW, thr_swipe),
            tick($urandom_range(0, stride)));
    end
    repeat ($urandom_range(3, 7)) begin
      kind = ($urandom_range(0, 5) == 0) ? LVL_HIGH : LVL_LOW;
      offer(pick_level(kind, thr_presence), any_swipe(), tick(stride + $urandom_range(0, 2)));
    end
  endtask

  // Unstructured items, with occasional jumps to an arbitrary timestamp.
  task automatic run_noise(int count);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) clock_ms = $urandom();
      offer(SW'($urandom()), SW'($urandom()),
            tick($urandom_range(0, 2 * (int'(dwell_limit) / 3 + 1))));
    end
  endtask

  task automatic run_random_part(int budget);
    int stop_at;
    stop_at = items_queued + budget;
    if ($urandom_range(0, 2) == 0) clock_ms = NOW_W'(32'hFFFF_0000) + NOW_W'($urandom_range(0, 65535));
    while (items_queued < stop_at) begin
      if ($urandom_range(0, 4) == 0) run_noise($urandom_range(1, 8));
      else run_episode();
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items under the reset setting: threshold 15, low below 13,
    // dwell 2000 ms.
    offer('0, '0, '0);                          // low while idle, nothing happens
    offer(LEVEL_MAX, LEVEL_MAX, 32'd100);       // entry timing starts
    offer(LEVEL_MAX, '0, 32'd2099);             // one short of the dwell
    offer(10'd16, LEVEL_MAX, 32'd2100);         // entry, and the swipe arms
    offer(10'd14, 10'd14, 32'd2200);            // inside both hysteresis bands
    offer(10'd13, 10'd12, 32'd2300);            // swipe completes
    offer(10'd12, 10'd16, 32'd3000);            // exit timing starts, swipe arms
    offer(LEVEL_MAX, 10'd13, 32'd4000);         // high sample leaves the exit timer alone
    offer(LEVEL_MAX, LEVEL_MAX, 32'd4999);
    offer('0, '0, 32'd5000);                    // exit; swipe ignored, stays armed
    offer(LEVEL_MAX, '0, 32'd5001);             // stale timing gives an entry at once
    offer('0, '0, 32'd6000);
    offer('0, '0, 32'd8000);                    // exit, timing kept
    offer('0, '0, 32'd10000);                   // stale timing runs out quietly
    offer(LEVEL_MAX, '0, 32'hFFFF_FF00);        // timing starts just before the wrap
    offer(LEVEL_MAX, '0, 32'h0000_06CF);
    offer(LEVEL_MAX, '0, 32'h0000_06D0);        // entry across the wrap
    offer(10'd15, 10'd15, 32'h0000_0700);       // exactly on both thresholds
    offer(LEVEL_MAX, LEVEL_MAX, 32'h0000_0800);
    offer(LEVEL_MAX, '0, 32'hFFFF_FFFF);
    offer('0, LEVEL_MAX, 32'h0000_1000);
    clock_ms = 32'h0000_1000;

    // Random visits over a range of settings, extremes included.
    apply_setting(200, 300, 20, 100);
    run_random_part(180);
    apply_setting(0, 0, 0, 0);
    run_random_part(160);
    apply_setting(1023, 1023, 1023, 65535);
    run_random_part(60);
    apply_setting(512, 100, 1023, 500);
    run_random_part(150);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    apply_setting(5, 1000, 3, 1);
    run_random_part(180);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    apply_setting(700, 40, 0, 65535);
    run_random_part(150);
    repeat (2) begin
      apply_setting($urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 64), $urandom_range(0, 3000));
      run_random_part(170);
    end

    // The receiver holds off for a long stretch while items keep coming, so
    // both internal registers fill and the input stalls.
    apply_setting(300, 300, 5, 10);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    hold_request   = 1'b1;
    run_random_part(40);

    // A burst of back-to-back swipes with no dwell.
    apply_setting(500, 500, 10, 0);
    offer(LEVEL_MAX, '0, tick(1));
    offer(LEVEL_MAX, '0, tick(1));
    repeat (SWIPE_BURST) begin
      offer(LEVEL_MAX, LEVEL_MAX, tick(1));
      offer(LEVEL_MAX, '0, tick(1));
    end

    // Closing stretch at the reset setting with no idling.
    apply_setting(RST_PRES_THR, RST_SWIPE_THR, RST_HYST, RST_DWELL);
    run_random_part(170);

    wait_idle();
    $display("Run covered %0d items over many settings, random idling, a long output",
             items_sent);
    $display("hold-off and a swipe burst: %0d results, %0d entries, %0d exits, %0d swipes.",
             results_seen, entry_total, exit_total, swipe_events);
    if (mismatch_count == 0) begin
      $display("tb_presence_dwell_and_swipe_detector: clean");
    end else begin
      $display("tb_presence_dwell_and_swipe_detector: errors");
    end
    $finish;
  end

  // Guard against a hung handshake; a correct run needs well under a third of this.
  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d results still awaited.", outcomes_due.size());
    $display("tb_presence_dwell_and_swipe_detector: errors");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/psd_pkg.sv
rtl/core/psd_cfg.sv
rtl/core/psd_step.sv
rtl/core/presence_dwell_and_swipe_detector.sv
dv/tb_presence_dwell_and_swipe_detector.sv
